// File: design/ladrc_pkg.sv
// ----------------------------------------------------------------------------
// ladrc_pkg
// Shared types, constants and the microcode program of the first-order
// linear ADRC controller.
// ----------------------------------------------------------------------------
package ladrc_pkg;

    // Default numeric format: Q16.16 inputs, 48-bit observer states.
    localparam int FRAC_BITS_DEF   = 16;
    localparam int STATE_WIDTH_DEF = 48;

    // Fixed widths of the words on the ports and of the internal magnitude path.
    localparam int WORD_W = 32;
    localparam int MAG_W  = 64;
    localparam int PROD_W = 96;

    // The restoring divider produces one quotient bit per step.
    localparam int DIV_BITS = 32;
    localparam int CNT_W    = $clog2(DIV_BITS);

    // Program counter width and the address of the divider loop step.
    localparam int PC_W = 6;
    localparam logic [PC_W-1:0] PC_DIV_LOOP = PC_W'(48);

    typedef enum logic [3:0] {
        OP_NOP,   // no datapath action
        OP_LDA,   // acc = operand
        OP_ADD,   // acc = sat(acc + operand)
        OP_SUB,   // acc = sat(acc - operand)
        OP_STA,   // operand register = acc
        OP_MAG,   // magnitude and sign of operand
        OP_MLO,   // low partial product with coefficient
        OP_MHI,   // high partial product with coefficient
        OP_NRM,   // sum, shift and saturate the product magnitude
        OP_SGN,   // acc = signed product
        OP_DVI,   // divider setup and overflow check
        OP_DVS,   // one restoring division step
        OP_QST,   // saturate and sign the quotient
        OP_CLP    // clamp, store last drive, emit result
    } t_op;

    typedef enum logic [3:0] {
        SRC_ACC,
        SRC_SP,
        SRC_FB,
        SRC_Z0,
        SRC_Z1,
        SRC_U,
        SRC_WOE,
        SRC_D0,
        SRC_D1
    } t_src;

    typedef enum logic [1:0] {
        CF_WC,
        CF_WO,
        CF_B0,
        CF_TS
    } t_coef;

    typedef enum logic {
        SH_FRAC,  // shift by the fraction width (Q16.16 factor)
        SH_WORD   // shift by a full word (Q0.32 factor)
    } t_shf;

    typedef enum logic [1:0] {
        JMP_NONE,  // fall through
        JMP_LOOP,  // jump to target while the loop counter is nonzero
        JMP_END    // end of program, wait for the output slot
    } t_jmp;

    typedef struct packed {
        t_op             op;
        t_src            src;
        t_coef           coef;
        t_shf            shf;
        t_jmp            jmp;
        logic [PC_W-1:0] target;
    } t_ctl;

    function automatic t_ctl cw(t_op op, t_src src, t_coef cf, t_shf sh, t_jmp jp,
                                logic [PC_W-1:0] tgt);
        t_ctl w;
        w.op     = op;
        w.src    = src;
        w.coef   = cf;
        w.shf    = sh;
        w.jmp    = jp;
        w.target = tgt;
        return w;
    endfunction

    // Plain register step.
    function automatic t_ctl st(t_op op, t_src src);
        return cw(op, src, CF_WC, SH_FRAC, JMP_NONE, '0);
    endfunction

    // Multiplier step.
    function automatic t_ctl mu(t_op op, t_coef cf, t_shf sh);
        return cw(op, SRC_ACC, cf, sh, JMP_NONE, '0);
    endfunction

    function automatic t_ctl nop_word();
        return cw(OP_NOP, SRC_ACC, CF_WC, SH_FRAC, JMP_NONE, '0);
    endfunction

    // The control program, one word per step.
    function automatic t_ctl rom_word(logic [PC_W-1:0] pc);
        t_ctl w;
        case (int'(pc))
            // Observer error e = fb - z0, then wo*e.
            0:  w = st(OP_LDA, SRC_FB);
            1:  w = st(OP_SUB, SRC_Z0);
            2:  w = st(OP_MAG, SRC_ACC);
            3:  w = mu(OP_MLO, CF_WO, SH_FRAC);
            4:  w = mu(OP_MHI, CF_WO, SH_FRAC);
            5:  w = mu(OP_NRM, CF_WO, SH_FRAC);
            6:  w = st(OP_SGN, SRC_ACC);
            7:  w = st(OP_STA, SRC_WOE);
            // d0 = 2*wo*e + z1 + b0*u.
            8:  w = st(OP_ADD, SRC_WOE);
            9:  w = st(OP_ADD, SRC_Z1);
            10: w = st(OP_STA, SRC_D0);
            11: w = st(OP_MAG, SRC_U);
            12: w = mu(OP_MLO, CF_B0, SH_FRAC);
            13: w = mu(OP_MHI, CF_B0, SH_FRAC);
            14: w = mu(OP_NRM, CF_B0, SH_FRAC);
            15: w = st(OP_SGN, SRC_ACC);
            16: w = st(OP_ADD, SRC_D0);
            17: w = st(OP_STA, SRC_D0);
            // d1 = (wo*e)*wo.
            18: w = st(OP_MAG, SRC_WOE);
            19: w = mu(OP_MLO, CF_WO, SH_FRAC);
            20: w = mu(OP_MHI, CF_WO, SH_FRAC);
            21: w = mu(OP_NRM, CF_WO, SH_FRAC);
            22: w = st(OP_SGN, SRC_ACC);
            23: w = st(OP_STA, SRC_D1);
            // z0 += ts*d0.
            24: w = st(OP_MAG, SRC_D0);
            25: w = mu(OP_MLO, CF_TS, SH_WORD);
            26: w = mu(OP_MHI, CF_TS, SH_WORD);
            27: w = mu(OP_NRM, CF_TS, SH_WORD);
            28: w = st(OP_SGN, SRC_ACC);
            29: w = st(OP_ADD, SRC_Z0);
            30: w = st(OP_STA, SRC_Z0);
            // z1 += ts*d1.
            31: w = st(OP_MAG, SRC_D1);
            32: w = mu(OP_MLO, CF_TS, SH_WORD);
            33: w = mu(OP_MHI, CF_TS, SH_WORD);
            34: w = mu(OP_NRM, CF_TS, SH_WORD);
            35: w = st(OP_SGN, SRC_ACC);
            36: w = st(OP_ADD, SRC_Z1);
            37: w = st(OP_STA, SRC_Z1);
            // Control law numerator wc*(sp - z0) - z1.
            38: w = st(OP_LDA, SRC_SP);
            39: w = st(OP_SUB, SRC_Z0);
            40: w = st(OP_MAG, SRC_ACC);
            41: w = mu(OP_MLO, CF_WC, SH_FRAC);
            42: w = mu(OP_MHI, CF_WC, SH_FRAC);
            43: w = mu(OP_NRM, CF_WC, SH_FRAC);
            44: w = st(OP_SGN, SRC_ACC);
            45: w = st(OP_SUB, SRC_Z1);
            // Divide by b0, saturate, clamp.
            46: w = st(OP_MAG, SRC_ACC);
            47: w = st(OP_DVI, SRC_ACC);
            48: w = cw(OP_DVS, SRC_ACC, CF_B0, SH_FRAC, JMP_LOOP, PC_DIV_LOOP);
            49: w = st(OP_QST, SRC_ACC);
            50: w = cw(OP_CLP, SRC_ACC, CF_WC, SH_FRAC, JMP_END, '0);
            default: w = cw(OP_NOP, SRC_ACC, CF_WC, SH_FRAC, JMP_END, '0);
        endcase
        return w;
    endfunction

endpackage

// File: design/first_order_ladrc_controller_unit.sv
// ----------------------------------------------------------------------------
// first_order_ladrc_controller_unit
// First-order linear ADRC: extended state observer plus control law, run by
// a microcoded sequencer over a shared multiplier and a radix-2 divider.
// ----------------------------------------------------------------------------
// Usage:
//   Each slave-side word carries one setpoint and one measured value. The
//   block advances the two observer estimates by one forward Euler step,
//   computes the drive (wc*(setpoint - z0) - z1) / b0, clamps it to the
//   drive limits, keeps it for the next observer step and sends it as one
//   master-side word.
//   The program runs the one-bit-per-cycle divider loop and the six
//   products, each taking five steps of the single 32x32 multiplier. A new
//   word can be accepted in the cycle after the result is loaded, so the
//   block works on one word at a time.
//   The output register separates the two sides: s_axis_tready returns high
//   while a finished drive still waits. If the receiver stalls and the next
//   drive is ready, the program holds on its last step until the register
//   is free; nothing is lost.
//   Reset (synchronous, active low) clears the observer estimates and the
//   stored drive to zero and loads the register defaults. The user must write
//   registers via the plain write port only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module first_order_ladrc_controller_unit #(
    parameter int FRAC_BITS   = ladrc_pkg::FRAC_BITS_DEF,
    parameter int STATE_WIDTH = ladrc_pkg::STATE_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Register write port.
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    // Slave side.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] setpoint, [63:32] measured
    // Master side.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] drive
);

    localparam logic [2:0] REG_CTRL_BW   = 3'd0;
    localparam logic [2:0] REG_OBS_BW    = 3'd1;
    localparam logic [2:0] REG_GAIN      = 3'd2;
    localparam logic [2:0] REG_PERIOD    = 3'd3;
    localparam logic [2:0] REG_DRV_UPPER = 3'd4;
    localparam logic [2:0] REG_DRV_LOWER = 3'd5;

    // Configuration registers.
    logic [31:0]        r_ctrl_bandwidth;
    logic [31:0]        r_observer_bandwidth;
    logic [30:0]        r_input_gain;
    logic [31:0]        r_sample_period;
    logic signed [31:0] r_drive_upper;
    logic signed [31:0] r_drive_lower;

    // Output register.
    logic               r_out_valid;
    logic [31:0]        r_out_data;

    logic               w_busy;
    logic               w_in_accept;
    logic               w_hold;
    logic               w_out_load;
    logic signed [31:0] w_drive;
    ladrc_pkg::t_ctl    w_ctl;

    assign s_axis_tready = !w_busy;
    assign w_in_accept   = s_axis_tvalid && !w_busy;

    // The last program step may only finish when the output register is free.
    assign w_hold     = r_out_valid && !m_axis_tready;
    assign w_out_load = (w_ctl.op == ladrc_pkg::OP_CLP) && !w_hold;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_bandwidth     <= 32'd65536;
            r_observer_bandwidth <= 32'd65536;
            r_input_gain         <= 31'd65536;
            r_sample_period      <= 32'd4294967;
            r_drive_upper        <= 32'sh7FFF_FFFF;
            r_drive_lower        <= 32'sh8000_0000;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                REG_CTRL_BW:   r_ctrl_bandwidth     <= i_cfg_wdata;
                REG_OBS_BW:    r_observer_bandwidth <= i_cfg_wdata;
                REG_GAIN:      r_input_gain         <= i_cfg_wdata[30:0];
                REG_PERIOD:    r_sample_period      <= i_cfg_wdata;
                REG_DRV_UPPER: r_drive_upper        <= i_cfg_wdata;
                REG_DRV_LOWER: r_drive_lower        <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= w_drive;
        end
    end

    ladrc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_in_accept),
        .i_hold  (w_hold),
        .o_busy  (w_busy),
        .o_ctl   (w_ctl)
    );

    ladrc_dp #(
        .FRAC_BITS   (FRAC_BITS),
        .STATE_WIDTH (STATE_WIDTH)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_ctl                (w_ctl),
        .i_load               (w_in_accept),
        .i_setpoint           (s_axis_tdata[31:0]),
        .i_measured           (s_axis_tdata[63:32]),
        .i_ctrl_bandwidth     (r_ctrl_bandwidth),
        .i_observer_bandwidth (r_observer_bandwidth),
        .i_input_gain         (r_input_gain),
        .i_sample_period      (r_sample_period),
        .i_drive_upper        (r_drive_upper),
        .i_drive_lower        (r_drive_lower),
        .o_drive              (w_drive)
    );

endmodule

// File: design/ladrc_seq.sv
// ----------------------------------------------------------------------------
// ladrc_seq
// Microcode sequencer: step counter, loop counter and control store.
// ----------------------------------------------------------------------------
module ladrc_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_hold,
    output logic               o_busy,
    output ladrc_pkg::t_ctl    o_ctl
);

    logic                            r_busy;
    logic [ladrc_pkg::PC_W-1:0]      r_pc;
    logic [ladrc_pkg::CNT_W-1:0]     r_cnt;
    ladrc_pkg::t_ctl                 w_word;

    assign w_word = ladrc_pkg::rom_word(r_pc);
    assign o_ctl  = r_busy ? w_word : ladrc_pkg::nop_word();
    assign o_busy = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= '0;
            r_cnt  <= '0;
        end else if (!r_busy) begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_pc   <= '0;
                r_cnt  <= ladrc_pkg::CNT_W'(ladrc_pkg::DIV_BITS - 1);
            end
        end else begin
            case (w_word.jmp)
                ladrc_pkg::JMP_NONE: begin
                    r_pc <= r_pc + 1'b1;
                end
                ladrc_pkg::JMP_LOOP: begin
                    if (r_cnt != '0) begin
                        r_cnt <= r_cnt - 1'b1;
                        r_pc  <= w_word.target;
                    end else begin
                        r_pc <= r_pc + 1'b1;
                    end
                end
                ladrc_pkg::JMP_END: begin
                    // The last step repeats until the output register is free.
                    if (!i_hold) begin
                        r_busy <= 1'b0;
                        r_pc   <= '0;
                    end
                end
                default: begin
                    r_busy <= 1'b0;
                    r_pc   <= '0;
                end
            endcase
        end
    end

endmodule

// File: design/ladrc_dp.sv
// ----------------------------------------------------------------------------
// ladrc_dp
// Datapath: accumulator, saturating adder, shared 32x32 multiplier and
// restoring divider, driven by one control word per cycle.
// ----------------------------------------------------------------------------
module ladrc_dp #(
    parameter int FRAC_BITS   = ladrc_pkg::FRAC_BITS_DEF,
    parameter int STATE_WIDTH = ladrc_pkg::STATE_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ladrc_pkg::t_ctl                    i_ctl,
    input  logic                               i_load,
    input  logic signed [ladrc_pkg::WORD_W-1:0] i_setpoint,
    input  logic signed [ladrc_pkg::WORD_W-1:0] i_measured,
    input  logic        [31:0]                 i_ctrl_bandwidth,
    input  logic        [31:0]                 i_observer_bandwidth,
    input  logic        [30:0]                 i_input_gain,
    input  logic        [31:0]                 i_sample_period,
    input  logic signed [ladrc_pkg::WORD_W-1:0] i_drive_upper,
    input  logic signed [ladrc_pkg::WORD_W-1:0] i_drive_lower,
    output logic signed [ladrc_pkg::WORD_W-1:0] o_drive
);

    localparam int SW     = STATE_WIDTH;
    localparam int MAG_W  = ladrc_pkg::MAG_W;
    localparam int PROD_W = ladrc_pkg::PROD_W;
    localparam int WORD_W = ladrc_pkg::WORD_W;
    localparam int DFW    = MAG_W + FRAC_BITS;
    localparam int DHW    = DFW - 32;

    localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = ~SMAX;
    localparam logic [MAG_W:0]       NEG_LIM_X = (MAG_W+1)'(1) << (SW-1);
    localparam logic [MAG_W-1:0]     NEG_LIM = NEG_LIM_X[MAG_W-1:0];
    localparam logic [MAG_W-1:0]     POS_LIM = NEG_LIM - 1'b1;
    localparam logic [WORD_W-1:0]    Q_NEG_LIM = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic [WORD_W-1:0]    Q_POS_LIM = {1'b0, {(WORD_W-1){1'b1}}};

    // Architectural state.
    logic signed [SW-1:0]     r_z0;
    logic signed [SW-1:0]     r_z1;
    logic signed [WORD_W-1:0] r_u;

    // Working registers.
    logic signed [SW-1:0]     r_acc;
    logic signed [WORD_W-1:0] r_sp;
    logic signed [WORD_W-1:0] r_fb;
    logic signed [SW-1:0]     r_woe;
    logic signed [SW-1:0]     r_d0;
    logic signed [SW-1:0]     r_d1;
    logic [MAG_W-1:0]         r_mag;
    logic                     r_neg;
    logic [MAG_W-1:0]         r_pa;
    logic [MAG_W-1:0]         r_pb;
    logic                     r_ovf;
    logic [30:0]              r_rem;
    logic [31:0]              r_dlo;
    logic [31:0]              r_quo;
    logic signed [WORD_W-1:0] r_res;

    logic signed [SW-1:0]     w_opnd;
    logic [31:0]              w_coef;
    logic signed [SW:0]       w_sum;
    logic signed [SW:0]       w_dif;
    logic signed [SW-1:0]     w_add_sat;
    logic signed [SW-1:0]     w_sub_sat;
    logic signed [MAG_W-1:0]  w_opnd_x;
    logic [MAG_W-1:0]         w_opnd_mag;
    logic [31:0]              w_mul_a;
    logic [MAG_W-1:0]         w_mul;
    logic [PROD_W-1:0]        w_prod;
    logic [PROD_W-1:0]        w_prod_shr;
    logic                     w_prod_over;
    logic [MAG_W-1:0]         w_nrm;
    logic [MAG_W-1:0]         w_neg_mag;
    logic [DFW-1:0]           w_dfull;
    logic [DHW-1:0]           w_dhi;
    logic [31:0]              w_trial;
    logic                     w_ge;
    logic [31:0]              w_b0x;
    logic [31:0]              w_qval;
    logic signed [WORD_W-1:0] w_clip_hi;
    logic signed [WORD_W-1:0] w_clip;

    // Operand and coefficient selection.
    always_comb begin
        case (i_ctl.src)
            ladrc_pkg::SRC_ACC: w_opnd = r_acc;
            ladrc_pkg::SRC_SP:  w_opnd = SW'(r_sp);
            ladrc_pkg::SRC_FB:  w_opnd = SW'(r_fb);
            ladrc_pkg::SRC_Z0:  w_opnd = r_z0;
            ladrc_pkg::SRC_Z1:  w_opnd = r_z1;
            ladrc_pkg::SRC_U:   w_opnd = SW'(r_u);
            ladrc_pkg::SRC_WOE: w_opnd = r_woe;
            ladrc_pkg::SRC_D0:  w_opnd = r_d0;
            ladrc_pkg::SRC_D1:  w_opnd = r_d1;
            default:            w_opnd = r_acc;
        endcase
    end

    assign w_b0x = {1'b0, i_input_gain};

    always_comb begin
        case (i_ctl.coef)
            ladrc_pkg::CF_WC: w_coef = i_ctrl_bandwidth;
            ladrc_pkg::CF_WO: w_coef = i_observer_bandwidth;
            ladrc_pkg::CF_B0: w_coef = w_b0x;
            ladrc_pkg::CF_TS: w_coef = i_sample_period;
            default:          w_coef = i_ctrl_bandwidth;
        endcase
    end

    // Saturating add and subtract: exact result one bit wider, then clipped.
    assign w_sum = (SW+1)'(r_acc) + (SW+1)'(w_opnd);
    assign w_dif = (SW+1)'(r_acc) - (SW+1)'(w_opnd);
    assign w_add_sat = (w_sum[SW] != w_sum[SW-1]) ? (w_sum[SW] ? SMIN : SMAX)
                                                  : w_sum[SW-1:0];
    assign w_sub_sat = (w_dif[SW] != w_dif[SW-1]) ? (w_dif[SW] ? SMIN : SMAX)
                                                  : w_dif[SW-1:0];

    // Magnitude of the operand; the most negative value maps to its exact size.
    assign w_opnd_x   = MAG_W'(w_opnd);
    assign w_opnd_mag = w_opnd_x[MAG_W-1] ? MAG_W'(-w_opnd_x) : MAG_W'(w_opnd_x);

    // One 32x32 multiplier serves both halves of the magnitude.
    assign w_mul_a = (i_ctl.op == ladrc_pkg::OP_MHI) ? r_mag[MAG_W-1:32] : r_mag[31:0];
    assign w_mul   = MAG_W'(w_mul_a) * MAG_W'(w_coef);

    // Product normalization, truncating the magnitude.
    assign w_prod      = PROD_W'(r_pa) + {r_pb, 32'd0};
    assign w_prod_shr  = (i_ctl.shf == ladrc_pkg::SH_WORD) ? (w_prod >> 32)
                                                           : (w_prod >> FRAC_BITS);
    assign w_prod_over = |w_prod_shr[PROD_W-1:SW-1];
    assign w_nrm       = w_prod_over ? (r_neg ? NEG_LIM : POS_LIM) : w_prod_shr[MAG_W-1:0];
    assign w_neg_mag   = MAG_W'(-r_mag);

    // Divider: the dividend is the magnitude scaled up by the fraction width.
    assign w_dfull = {r_mag, {FRAC_BITS{1'b0}}};
    assign w_dhi   = w_dfull[DFW-1:32];
    assign w_trial = {r_rem, r_dlo[31]};
    assign w_ge    = (w_trial >= w_b0x);

    // Quotient saturation to the signed word range.
    always_comb begin
        if (r_mag == '0) begin
            w_qval = '0;
        end else if (r_ovf) begin
            w_qval = r_neg ? Q_NEG_LIM : Q_POS_LIM;
        end else if (r_neg) begin
            w_qval = (r_quo > Q_NEG_LIM) ? Q_NEG_LIM : r_quo;
        end else begin
            w_qval = (r_quo > Q_POS_LIM) ? Q_POS_LIM : r_quo;
        end
    end

    // Upper limit first, then lower, so the lower limit wins if they cross.
    assign w_clip_hi = (r_res > i_drive_upper) ? i_drive_upper : r_res;
    assign w_clip    = (w_clip_hi < i_drive_lower) ? i_drive_lower : w_clip_hi;
    assign o_drive   = w_clip;

    // Controller state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z0 <= '0;
            r_z1 <= '0;
            r_u  <= '0;
        end else begin
            if (i_ctl.op == ladrc_pkg::OP_STA) begin
                if (i_ctl.src == ladrc_pkg::SRC_Z0) begin
                    r_z0 <= r_acc;
                end
                if (i_ctl.src == ladrc_pkg::SRC_Z1) begin
                    r_z1 <= r_acc;
                end
            end
            if (i_ctl.op == ladrc_pkg::OP_CLP) begin
                r_u <= w_clip;
            end
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sp <= i_setpoint;
            r_fb <= i_measured;
        end
        case (i_ctl.op)
            ladrc_pkg::OP_LDA: r_acc <= w_opnd;
            ladrc_pkg::OP_ADD: r_acc <= w_add_sat;
            ladrc_pkg::OP_SUB: r_acc <= w_sub_sat;
            ladrc_pkg::OP_STA: begin
                if (i_ctl.src == ladrc_pkg::SRC_WOE) begin
                    r_woe <= r_acc;
                end
                if (i_ctl.src == ladrc_pkg::SRC_D0) begin
                    r_d0 <= r_acc;
                end
                if (i_ctl.src == ladrc_pkg::SRC_D1) begin
                    r_d1 <= r_acc;
                end
            end
            ladrc_pkg::OP_MAG: begin
                r_mag <= w_opnd_mag;
                r_neg <= w_opnd[SW-1];
            end
            ladrc_pkg::OP_MLO: r_pa <= w_mul;
            ladrc_pkg::OP_MHI: r_pb <= w_mul;
            ladrc_pkg::OP_NRM: r_mag <= w_nrm;
            ladrc_pkg::OP_SGN: r_acc <= r_neg ? w_neg_mag[SW-1:0] : r_mag[SW-1:0];
            ladrc_pkg::OP_DVI: begin
                // A quotient of 2^32 or more always saturates.
                r_ovf <= (w_dhi >= DHW'(w_b0x)) && (r_mag != '0);
                r_rem <= w_dhi[30:0];
                r_dlo <= w_dfull[31:0];
            end
            ladrc_pkg::OP_DVS: begin
                r_rem <= w_ge ? 31'(w_trial - w_b0x) : w_trial[30:0];
                r_dlo <= {r_dlo[30:0], 1'b0};
                r_quo <= {r_quo[30:0], w_ge};
            end
            ladrc_pkg::OP_QST: r_res <= r_neg ? WORD_W'(-w_qval) : WORD_W'(w_qval);
            default: begin
            end
        endcase
    end

endmodule

// File: tb/tb_first_order_ladrc_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_order_ladrc_controller_unit
// Self-checking bench for the first-order linear ADRC controller. A built-in
// fixed-point model of the observer and control law predicts every drive
// word. Both stream sides idle and stall at random while register settings
// sweep from reset values through extremes, zero gain and crossed limits.
// ----------------------------------------------------------------------------
module tb_first_order_ladrc_controller_unit;

    // Register map of the plain write port. The two top indexes are unused and
    // must be ignored by the block.
    typedef enum logic [2:0] {
        REG_CTRL_BW,
        REG_OBS_BW,
        REG_INPUT_GAIN,
        REG_PERIOD,
        REG_DRIVE_UP,
        REG_DRIVE_LO,
        REG_SPARE_A,
        REG_SPARE_B
    } t_reg_index;

    localparam int FRAC = ladrc_pkg::FRAC_BITS_DEF;
    localparam int SW   = ladrc_pkg::STATE_WIDTH_DEF;

    // Observer states saturate to the signed state width.
    localparam longint ST_MAX = (longint'(1) << (SW - 1)) - 1;
    localparam longint ST_MIN = -ST_MAX - 1;

    localparam logic [31:0] ONE_Q16      = 32'h0001_0000;
    localparam logic [31:0] PERIOD_RESET = 32'd4294967;
    localparam logic [31:0] LEVEL_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0] LEVEL_MIN    = 32'h8000_0000;

    localparam int RANDOM_PHASES   = 10;
    localparam int PHASE_SAMPLES   = 53;
    localparam int TX_LONG         = 120;
    localparam int RX_LONG         = 250;
    localparam int SETTLE_CYCLES   = 4;
    localparam int END_CYCLES      = 100;
    localparam int WATCHDOG_LIMIT  = 3000;

    // ------------------------------------------------------------------------
    // Block ports. Every input holds a known value from time zero.
    // ------------------------------------------------------------------------
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [2:0]  i_cfg_addr    = REG_CTRL_BW;
    logic [31:0] i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;   // [31:0] setpoint, [63:32] measured
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [31:0] drive

    first_order_ladrc_controller_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Controller model: register copies and observer state, as after reset.
    // ------------------------------------------------------------------------
    logic [31:0]        gain_wc   = ONE_Q16;
    logic [31:0]        gain_wo   = ONE_Q16;
    logic [30:0]        gain_b0   = 31'(ONE_Q16);
    logic [31:0]        period_ts = PERIOD_RESET;
    logic signed [31:0] limit_up  = LEVEL_MAX;
    logic signed [31:0] limit_lo  = LEVEL_MIN;

    longint est_out    = 0;
    longint est_dist   = 0;
    longint prev_drive = 0;

    // Drive words predicted for accepted samples, oldest first.
    logic [31:0] drive_expected[$];

    int  failures       = 0;
    int  samples_sent   = 0;
    int  drives_checked = 0;
    int  settings_used  = 0;
    int  quiet_cycles   = 0;
    int  rx_hold        = 0;
    // When set, neither side inserts gaps, so the block runs back to back.
    bit  steady         = 1'b0;
    // Simple plant that follows the drive, used to close the loop.
    logic signed [31:0] plant_y = '0;

    function automatic longint sat_state(input longint v);
        if (v > ST_MAX) return ST_MAX;
        if (v < ST_MIN) return ST_MIN;
        return v;
    endfunction

    function automatic logic signed [31:0] clip_word(input longint v);
        if (v > longint'($signed(LEVEL_MAX))) return LEVEL_MAX;
        if (v < longint'($signed(LEVEL_MIN))) return LEVEL_MIN;
        return v[31:0];
    endfunction

    // Exact product of a state value and an unsigned coefficient, shifted
    // right with the magnitude truncated, then saturated to the state range.
    function automatic longint scaled_product(input longint value, input logic [31:0] coef,
                                              input int shift);
        logic [127:0] mag;
        logic [127:0] prod;
        mag  = (value < 0) ? 128'(-value) : 128'(value);
        prod = (mag * {96'd0, coef}) >> shift;
        if (prod > 128'(ST_MAX)) return (value < 0) ? ST_MIN : ST_MAX;
        return (value < 0) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    // Numerator over b0 in Q16.16, truncated toward zero, saturated to a
    // signed word. A zero gain gives the word limit with the numerator's sign.
    function automatic longint divide_by_gain(input longint num, input logic [30:0] gain);
        logic [63:0] mag;
        logic [63:0] quo;
        logic [63:0] rem;
        logic [63:0] val;
        mag = (num < 0) ? 64'(-num) : 64'(num);
        if (gain == '0) begin
            val = (mag == 0) ? 64'd0 : 64'h8000_0000;
        end else begin
            quo = mag / {33'd0, gain};
            rem = mag % {33'd0, gain};
            if (quo >= 64'h1_0000_0000)
                val = 64'h8000_0000;
            else
                val = (quo << FRAC) + ((rem << FRAC) / {33'd0, gain});
        end
        if (num < 0) begin
            if (val > 64'h8000_0000) val = 64'h8000_0000;
            return -longint'(val);
        end
        if (val > 64'h7FFF_FFFF) val = 64'h7FFF_FFFF;
        return longint'(val);
    endfunction

    // One observer step followed by the control law; returns the drive word
    // and keeps it for the next observer step.
    function automatic logic [31:0] advance_controller(input logic signed [31:0] target,
                                                       input logic signed [31:0] feedback);
        longint err, wo_err, d0, d1, num, res;
        err    = sat_state(longint'(feedback) - est_out);
        wo_err = scaled_product(err, gain_wo, FRAC);
        d0     = sat_state(wo_err + wo_err);
        d0     = sat_state(d0 + est_dist);
        d0     = sat_state(d0 + scaled_product(prev_drive, {1'b0, gain_b0}, FRAC));
        d1     = scaled_product(wo_err, gain_wo, FRAC);
        est_out  = sat_state(est_out + scaled_product(d0, period_ts, 32));
        est_dist = sat_state(est_dist + scaled_product(d1, period_ts, 32));
        num = scaled_product(sat_state(longint'(target) - est_out), gain_wc, FRAC);
        num = sat_state(num - est_dist);
        res = divide_by_gain(num, gain_b0);
        // Upper limit first, so a crossed lower limit wins.
        if (res > longint'(limit_up)) res = limit_up;
        if (res < longint'(limit_lo)) res = limit_lo;
        prev_drive = res;
        return res[31:0];
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap(input int long_max);
        int roll;
        if (steady) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 5);
        return $urandom_range(20, long_max);
    endfunction

    // Sample levels: mostly within +/-128.0, sometimes extremes or raw bits.
    function automatic logic signed [31:0] pick_level();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) return $urandom;
        if (roll == 1) begin
            case ($urandom_range(0, 3))
                0:       return LEVEL_MAX;
                1:       return LEVEL_MIN;
                2:       return '0;
                default: return '1;
            endcase
        end
        return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: stall at random, compare each drive word with the oldest
    // prediction.
    // ------------------------------------------------------------------------
    task automatic check_drive(input logic [31:0] actual);
        logic [31:0] want;
        if (drive_expected.size() == 0) begin
            failures++;
            $error("drive word %h arrived with no sample pending", actual);
        end else begin
            want = drive_expected.pop_front();
            drives_checked++;
            if (want !== actual) begin
                failures++;
                $error("drive mismatch: expected %h, actual %h", want, actual);
            end
        end
    endtask

    always @(posedge i_clk) begin
        int pause;
        pause = rx_hold;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            check_drive(m_axis_tdata);
            pause = pick_gap(RX_LONG);
        end
        if (pause > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold       <= pause - 1;
        end else begin
            m_axis_tready <= 1'b1;
            rx_hold       <= 0;
        end
    end

    // The watchdog counts cycles in which no word moves on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $error("no word accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sample side and register writes. All of these start and end at a
    // rising edge.
    // ------------------------------------------------------------------------
    // Offers one setpoint and measurement; the prediction is queued at the
    // accepting edge. tvalid stays high so a following word can go back to
    // back.
    task automatic send_sample(input logic signed [31:0] target,
                               input logic signed [31:0] feedback);
        int gap;
        gap = pick_gap(TX_LONG);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {feedback, target};
        do @(posedge i_clk); while (!s_axis_tready);
        drive_expected.push_back(advance_controller(target, feedback));
        samples_sent++;
    endtask

    // Holds the sender until every pending drive has been received, leaving
    // the block idle for register writes.
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        while (drive_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic write_reg(input t_reg_index index, input logic [31:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= index;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        case (index)
            REG_CTRL_BW:    gain_wc   = value;
            REG_OBS_BW:     gain_wo   = value;
            REG_INPUT_GAIN: gain_b0   = value[30:0];
            REG_PERIOD:     period_ts = value;
            REG_DRIVE_UP:   limit_up  = value;
            REG_DRIVE_LO:   limit_lo  = value;
            default:        ;
        endcase
    endtask

    task automatic program_loop(input logic [31:0] wc, input logic [31:0] wo,
                                input logic [31:0] b0, input logic [31:0] ts,
                                input logic [31:0] up, input logic [31:0] lo);
        write_reg(REG_CTRL_BW, wc);
        write_reg(REG_OBS_BW, wo);
        write_reg(REG_INPUT_GAIN, b0);
        write_reg(REG_PERIOD, ts);
        write_reg(REG_DRIVE_UP, up);
        write_reg(REG_DRIVE_LO, lo);
        i_cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------
    // Register values straight out of reset, with the sample extremes.
    task automatic test_reset_defaults();
        send_sample('0, '0);
        send_sample(LEVEL_MAX, LEVEL_MIN);
        send_sample(LEVEL_MIN, LEVEL_MAX);
        send_sample('1, 32'sd1);
        drain_pipeline();
    endtask

    // A zero input gain, reached through a gain write whose only set bit lies
    // above the 31-bit register. With wo and ts at zero the estimates freeze,
    // and with wc at one the numerator is setpoint - z0 - z1, so a setpoint
    // equal to z0 + z1 gives the zero numerator case.
    task automatic test_zero_gain();
        longint balance;
        program_loop(ONE_Q16, '0, 32'h8000_0000, '0, LEVEL_MAX, LEVEL_MIN);
        balance = est_out + est_dist;
        send_sample(clip_word(balance), $urandom);
        send_sample(clip_word(balance + 1), $urandom);
        send_sample(clip_word(balance - 1), $urandom);
        send_sample(LEVEL_MAX, '0);
        send_sample(LEVEL_MIN, '0);
        drain_pipeline();
    endtask

    // Lower limit above the upper one, then a narrow ordinary window.
    task automatic test_crossed_limits();
        program_loop(32'h0002_0000, 32'h0003_0000, ONE_Q16, 32'd42949673,
                     32'hFFFF_0000, ONE_Q16);
        repeat (3) send_sample(pick_level(), pick_level());
        drain_pipeline();
        program_loop(32'h0002_0000, 32'h0003_0000, ONE_Q16, 32'd42949673,
                     32'h0000_4000, 32'hFFFF_8000);
        repeat (3) send_sample(pick_level(), pick_level());
        drain_pipeline();
    endtask

    // Writes to the unused indexes must leave every setting alone.
    task automatic test_spare_index();
        write_reg(REG_SPARE_A, '1);
        write_reg(REG_SPARE_B, '0);
        i_cfg_wr_en <= 1'b0;
        send_sample(32'sh0001_8000, 32'shFFFF_0000);
        send_sample(32'sh0010_0000, 32'sh0008_0000);
        drain_pipeline();
    endtask

    // All-ones and minimal settings, driving the estimates into saturation.
    task automatic test_register_extremes();
        program_loop('1, '1, '1, '1, LEVEL_MAX, LEVEL_MIN);
        send_sample(LEVEL_MAX, LEVEL_MIN);
        send_sample(LEVEL_MIN, LEVEL_MAX);
        drain_pipeline();
        program_loop('0, '0, 32'd1, '0, LEVEL_MAX, LEVEL_MIN);
        send_sample(LEVEL_MAX, '0);
        send_sample(LEVEL_MIN, LEVEL_MAX);
        drain_pipeline();
        program_loop('1, '1, 32'd1, '1, LEVEL_MAX, LEVEL_MIN);
        send_sample('0, LEVEL_MAX);
        send_sample(LEVEL_MIN, '0);
        drain_pipeline();
    endtask

    // Mostly ordinary tuning, with the occasional raw register value.
    task automatic randomize_settings();
        logic [31:0] wc, wo, b0, ts, up, lo;
        wc = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 32'h0028_0000);
        wo = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 32'h0028_0000);
        b0 = ($urandom_range(0, 9) == 0) ? $urandom
                                         : $urandom_range(32'h0000_1000, 32'h0008_0000);
        ts = ($urandom_range(0, 9) == 0) ? $urandom
                                         : $urandom_range(32'h0040_0000, 32'h2000_0000);
        case ($urandom_range(0, 9))
            0: begin
                up = LEVEL_MAX;
                lo = LEVEL_MIN;
            end
            1: begin
                up = $urandom;
                lo = $urandom;
            end
            default: begin
                up = $urandom_range(32'h0001_0000, 32'h00C8_0000);
                lo = -$urandom_range(32'h0001_0000, 32'h00C8_0000);
            end
        endcase
        program_loop(wc, wo, b0, ts, up, lo);
    endtask

    // Closed-loop operation: the measurement follows a plant driven by the
    // predicted drive, the setpoint steps now and then, and a few samples
    // carry arbitrary measurements. Now and then the sender waits for every
    // pending drive before going on.
    task automatic test_random_operation();
        logic signed [31:0] target;
        logic signed [31:0] feedback;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_pipeline();
            randomize_settings();
            steady = ($urandom_range(0, 3) == 0);
            target = pick_level();
            for (int n = 0; n < PHASE_SAMPLES; n++) begin
                if ($urandom_range(0, 11) == 0) target = pick_level();
                plant_y = clip_word(longint'(plant_y) + (prev_drive >>> 4)
                                    + longint'($urandom_range(0, 2048)) - 1024);
                feedback = ($urandom_range(0, 9) == 0) ? pick_level() : plant_y;
                send_sample(target, feedback);
                if ($urandom_range(0, 39) == 0) drain_pipeline();
            end
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence: reset once, directed checks, random operation, then let the
    // last drive words come out before the verdict.
    // ------------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_zero_gain();
        test_crossed_limits();
        test_spare_index();
        test_register_extremes();
        test_random_operation();

        drain_pipeline();
        repeat (END_CYCLES) @(posedge i_clk);

        $display("Ran %0d setpoint/measurement words under %0d register settings,",
                 samples_sent, settings_used);
        $display("%0d drives compared; covered zero gain, crossed limits, ignored %s",
                 drives_checked, "indexes, saturated estimates and stalls.");
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sim.f
design/ladrc_pkg.sv
design/ladrc_seq.sv
design/ladrc_dp.sv
design/first_order_ladrc_controller_unit.sv
tb/tb_first_order_ladrc_controller_unit.sv
